// ----- rtl/motion_command_interpreter_assert.svh -----
// Assertion macros for the motion command interpreter.
// Included by the top level; needs no package.
`ifndef MOTION_COMMAND_INTERPRETER_ASSERT_SVH
`define MOTION_COMMAND_INTERPRETER_ASSERT_SVH

// Check cons in the same cycle as ante.
`define MCI_ASSERT_SAME(label, ck, rn, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("motion command interpreter check failed");

// Check cons in the cycle after ante.
`define MCI_ASSERT_NEXT(label, ck, rn, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("motion command interpreter check failed");

`endif

// ----- rtl/mci_pkg.sv -----
// Shared types and constants of the motion command interpreter.
// Used by mci_decode, mci_mix and motion_command_interpreter; no dependencies.
package mci_pkg;

	// Command word ranges
	localparam logic [15:0] CMD_BASE     = 16'd32768;
	localparam logic [15:0] JUMP_LO      = 16'd33031;
	localparam logic [15:0] JUMP_HI      = 16'd33286;
	localparam logic [15:0] LOOP_SET_LO  = 16'd33287;
	localparam logic [15:0] LOOP_SET_HI  = 16'd33542;
	localparam logic [15:0] LOOP_DEC_LO  = 16'd33543;
	localparam logic [15:0] LOOP_DEC_HI  = 16'd33798;
	localparam logic [15:0] CMP_SET_LO   = 16'd39942;
	localparam logic [15:0] CMP_SET_HI   = 16'd57348;
	localparam logic [15:0] CMP_RAW_LO   = 16'd35846;
	localparam logic [15:0] CMP_RAW_HI   = 16'd36613;
	localparam logic [15:0] BTN_EQ_LO    = 16'd39430;
	localparam logic [15:0] BTN_EQ_HI    = 16'd39685;
	localparam logic [15:0] BTN_AND_LO   = 16'd39686;
	localparam logic [15:0] BTN_AND_HI   = 16'd39941;
	localparam logic [15:0] MIX_MOT_LO   = 16'd36614;
	localparam logic [15:0] MIX_MOT_HI   = 16'd37381;
	localparam logic [15:0] MIX_LIVE_LO  = 16'd64500;
	localparam logic [15:0] MIX_LIVE_HI  = 16'd65267;
	localparam logic [15:0] ORIGIN_LO    = 16'd65268;
	localparam logic [15:0] ORIGIN_HI    = 16'd65270;
	localparam logic [15:0] CMP_REL_LO   = 16'd37382;
	localparam logic [15:0] CMP_REL_HI   = 16'd38149;

	localparam logic [14:0] CMP_OFFSET   = 15'd1023;
	localparam logic [7:0]  MIX_EN_LIMIT = 8'd128;
	localparam logic [5:0]  FAC_MASK     = 6'h3F;
	localparam logic [9:0]  ORIGIN_GYRO  = 10'd276;

	localparam int NUM_SENSORS = 3;

	// Architectural state of the interpreter
	typedef struct packed {
		logic [15:0]      loop_counter;
		logic [14:0]      compare_reg;
		logic [2:0][9:0]  origin;
		logic [2:0]       mm_en;
		logic [2:0][6:0]  mm_fac;
		logic [2:0]       lm_en;
		logic [2:0][6:0]  lm_fac;
		logic [2:0]       mm_cnt;
		logic [2:0]       lm_cnt;
	} mci_state_t;

	localparam mci_state_t STATE_RESET = '{
		loop_counter: 16'd0,
		compare_reg:  15'd0,
		origin:       {10'd0, ORIGIN_GYRO, ORIGIN_GYRO},
		mm_en:        3'd0,
		mm_fac:       '0,
		lm_en:        3'd0,
		lm_fac:       '0,
		mm_cnt:       3'd0,
		lm_cnt:       3'd0
	};

	// Per-item decode flags
	typedef struct packed {
		logic is_command;
		logic recognized;
		logic take_default_link;
		logic mix_on;
	} dec_flags_t;

endpackage

// ----- rtl/mci_decode.sv -----
// Command word decoder and next-state logic of the motion command interpreter.
// Depends on mci_pkg.
module mci_decode import mci_pkg::*; (
	input  logic             op,
	input  logic [15:0]      command_word,
	input  logic [2:0][9:0]  sensors,
	input  logic [10:0]      button_code,
	input  mci_state_t       st,
	output mci_state_t       st_next,
	output dec_flags_t       flags
);

	typedef enum logic [3:0] {
		CMD_PLAIN, CMD_JUMP, CMD_LOOP_SET, CMD_LOOP_DEC, CMD_CMP_SET, CMD_CMP_RAW,
		CMD_BTN_EQ, CMD_BTN_AND, CMD_MIX_MOT, CMD_MIX_LIVE, CMD_ORIGIN, CMD_CMP_REL,
		CMD_UNKNOWN
	} cmd_t;

	cmd_t               cmd;
	logic [15:0]        base;
	logic [15:0]        off;
	logic [1:0]         idx;
	logic [9:0]         sen;
	logic [9:0]         org;
	logic signed [15:0] cmp16;
	logic signed [10:0] rel;
	logic [7:0]         val;
	logic               en_new;
	logic [6:0]         fac_new;
	logic               was;

	// Classify the word by range
	always_comb begin
		cmd  = CMD_UNKNOWN;
		base = CMD_BASE;
		if (command_word < CMD_BASE) begin
			cmd = CMD_PLAIN;
		end else if (command_word inside {[JUMP_LO:JUMP_HI]}) begin
			cmd = CMD_JUMP;
			base = JUMP_LO;
		end else if (command_word inside {[LOOP_SET_LO:LOOP_SET_HI]}) begin
			cmd = CMD_LOOP_SET;
			base = LOOP_SET_LO;
		end else if (command_word inside {[LOOP_DEC_LO:LOOP_DEC_HI]}) begin
			cmd = CMD_LOOP_DEC;
			base = LOOP_DEC_LO;
		end else if (command_word inside {[CMP_SET_LO:CMP_SET_HI]}) begin
			cmd = CMD_CMP_SET;
			base = CMP_SET_LO;
		end else if (command_word inside {[CMP_RAW_LO:CMP_RAW_HI]}) begin
			cmd = CMD_CMP_RAW;
			base = CMP_RAW_LO;
		end else if (command_word inside {[BTN_EQ_LO:BTN_EQ_HI]}) begin
			cmd = CMD_BTN_EQ;
			base = BTN_EQ_LO;
		end else if (command_word inside {[BTN_AND_LO:BTN_AND_HI]}) begin
			cmd = CMD_BTN_AND;
			base = BTN_AND_LO;
		end else if (command_word inside {[MIX_MOT_LO:MIX_MOT_HI]}) begin
			cmd = CMD_MIX_MOT;
			base = MIX_MOT_LO;
		end else if (command_word inside {[MIX_LIVE_LO:MIX_LIVE_HI]}) begin
			cmd = CMD_MIX_LIVE;
			base = MIX_LIVE_LO;
		end else if (command_word inside {[ORIGIN_LO:ORIGIN_HI]}) begin
			cmd = CMD_ORIGIN;
			base = ORIGIN_LO;
		end else if (command_word inside {[CMP_REL_LO:CMP_REL_HI]}) begin
			cmd = CMD_CMP_REL;
			base = CMP_REL_LO;
		end
	end

	// Operands shared by the command kinds
	always_comb begin
		off = command_word - base;
		idx = (cmd == CMD_ORIGIN) ? off[1:0] : off[9:8];
		sen = sensors[0];
		org = st.origin[0];
		for (int i = 1; i < NUM_SENSORS; i++) begin
			if (idx == 2'(i)) begin
				sen = sensors[i];
				org = st.origin[i];
			end
		end
		cmp16   = $signed({st.compare_reg[14], st.compare_reg});
		rel     = $signed({1'b0, sen}) - $signed({1'b0, org});
		val     = off[7:0];
		en_new  = val > MIX_EN_LIMIT;
		fac_new = val[6] ? 7'(-{1'b0, val[5:0] & FAC_MASK}) : {1'b0, val[5:0] & FAC_MASK};
		was     = (cmd == CMD_MIX_LIVE) ? st.lm_en[idx] : st.mm_en[idx];
	end

	// Apply the command
	always_comb begin
		st_next = st;
		flags.is_command        = 1'b0;
		flags.recognized        = 1'b0;
		flags.take_default_link = 1'b1;
		flags.mix_on            = !op;
		if (op) begin
			st_next.mm_cnt = 3'd0;
		end else begin
			flags.is_command = (cmd != CMD_PLAIN);
			flags.recognized = (cmd != CMD_PLAIN) && (cmd != CMD_UNKNOWN);
			case (cmd)
				CMD_LOOP_SET: begin
					st_next.loop_counter = {8'd0, off[7:0]};
				end
				CMD_LOOP_DEC: begin
					st_next.loop_counter = st.loop_counter - {8'd0, off[7:0]} - 16'd1;
					flags.take_default_link = (st_next.loop_counter == 16'd0);
				end
				CMD_CMP_SET: begin
					st_next.compare_reg = off[14:0] - CMP_OFFSET;
				end
				CMD_CMP_RAW: begin
					flags.take_default_link = !($signed({6'd0, sen}) <= cmp16);
				end
				CMD_BTN_EQ: begin
					flags.take_default_link = !($signed({5'd0, button_code}) == cmp16);
				end
				CMD_BTN_AND: begin
					flags.take_default_link = ((button_code & st.compare_reg[10:0]) == 11'd0);
				end
				CMD_MIX_MOT: begin
					st_next.mm_en[idx]  = en_new;
					st_next.mm_fac[idx] = fac_new;
					if (was && !en_new) begin
						st_next.mm_cnt = st.mm_cnt - 3'd1;
					end else if (!was && en_new) begin
						st_next.mm_cnt = st.mm_cnt + 3'd1;
					end
				end
				CMD_MIX_LIVE: begin
					st_next.lm_en[idx]  = en_new;
					st_next.lm_fac[idx] = fac_new;
					if (was && !en_new) begin
						st_next.lm_cnt = st.lm_cnt - 3'd1;
					end else if (!was && en_new) begin
						st_next.lm_cnt = st.lm_cnt + 3'd1;
					end
				end
				CMD_ORIGIN: begin
					st_next.origin[idx] = sen;
				end
				CMD_CMP_REL: begin
					flags.take_default_link = !(16'(rel) <= cmp16);
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// ----- rtl/mci_mix.sv -----
// Mixing offset: factor times sensor-minus-origin summed over enabled mixes.
// Depends on mci_pkg.
module mci_mix import mci_pkg::*; (
	input  logic [2:0][9:0]    sensors,
	input  mci_state_t         st,
	input  logic               mix_on,
	output logic signed [18:0] mix_adjust
);

	logic [2:0]         en;
	logic [2:0][6:0]    fac;
	logic signed [10:0] diff [NUM_SENSORS];
	logic signed [17:0] prod [NUM_SENSORS];
	logic signed [19:0] sum;

	// Pick the motion mixes first, then the realtime mixes
	always_comb begin
		if (st.mm_cnt != 3'd0) begin
			en  = st.mm_en;
			fac = st.mm_fac;
		end else if (st.lm_cnt != 3'd0) begin
			en  = st.lm_en;
			fac = st.lm_fac;
		end else begin
			en  = 3'd0;
			fac = '0;
		end
	end

	// One small multiply per sensor lane, then add
	always_comb begin
		sum = '0;
		for (int i = 0; i < NUM_SENSORS; i++) begin
			diff[i] = $signed({1'b0, sensors[i]}) - $signed({1'b0, st.origin[i]});
			prod[i] = en[i] ? $signed(fac[i]) * diff[i] : 18'sd0;
			sum     = sum + 20'(prod[i]);
		end
		mix_adjust = mix_on ? sum[18:0] : 19'sd0;
	end

endmodule

// ----- rtl/motion_command_interpreter.sv -----
// Motion command interpreter top level: input register, state, result register.
// Depends on mci_pkg, mci_decode, mci_mix and motion_command_interpreter_assert.svh.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one item: op, command_word, the
//   three sensor levels and button_code. Output channel (out_valid/out_ready)
//   returns exactly one result per item, in order.
//   Flow: an accepted item sits in the input register, is decoded and its
//   result loaded once the result register is free or draining; out_valid is high after it.
//   Throughput: one item per cycle while out_ready stays high. Decode,
//   state update and the three 7x11 multiplies are combinational logic
//   between the input and result registers.
//   Stall: with out_ready low the result register holds; one more item
//   waits in the input register, then in_ready drops.
//   Reset: loop counter and compare register clear, origins return to
//   276, 276, 0, all mixes disabled and both mix counts cleared; both
//   channels come up empty.
`include "motion_command_interpreter_assert.svh"

module motion_command_interpreter import mci_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               op,
	input  logic [15:0]        command_word,
	input  logic [9:0]         sensor_a,
	input  logic [9:0]         sensor_b,
	input  logic [9:0]         sensor_c,
	input  logic [10:0]        button_code,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               is_command,
	output logic               recognized,
	output logic               take_default_link,
	output logic signed [15:0] loop_count,
	output logic signed [14:0] compare_value,
	output logic signed [18:0] mix_adjust
);

	logic               valid_s1;
	logic               op_s1;
	logic [15:0]        word_s1;
	logic [2:0][9:0]    sensors_s1;
	logic [10:0]        button_s1;
	logic               load_out;

	mci_state_t         st_q;
	mci_state_t         st_next;
	dec_flags_t         flags;
	logic signed [18:0] mix_next;

	logic               out_valid_q;
	logic               is_command_q;
	logic               recognized_q;
	logic               take_default_link_q;
	logic [15:0]        loop_count_q;
	logic [14:0]        compare_value_q;
	logic signed [18:0] mix_adjust_q;

	// Advance the input stage when the result register is free or draining
	assign load_out = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || load_out;

	// Hold the input item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (load_out) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1      <= op;
			word_s1    <= command_word;
			sensors_s1 <= {sensor_c, sensor_b, sensor_a};
			button_s1  <= button_code;
		end
	end

	mci_decode u_decode (
		.op           (op_s1),
		.command_word (word_s1),
		.sensors      (sensors_s1),
		.button_code  (button_s1),
		.st           (st_q),
		.st_next      (st_next),
		.flags        (flags)
	);

	mci_mix u_mix (
		.sensors    (sensors_s1),
		.st         (st_next),
		.mix_on     (flags.mix_on),
		.mix_adjust (mix_next)
	);

	// Commit state together with the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= STATE_RESET;
		end else if (load_out) begin
			st_q <= st_next;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			is_command_q        <= flags.is_command;
			recognized_q        <= flags.recognized;
			take_default_link_q <= flags.take_default_link;
			loop_count_q        <= st_next.loop_counter;
			compare_value_q     <= st_next.compare_reg;
			mix_adjust_q        <= mix_next;
		end
	end

	assign out_valid         = out_valid_q;
	assign is_command        = is_command_q;
	assign recognized        = recognized_q;
	assign take_default_link = take_default_link_q;
	assign loop_count        = $signed(loop_count_q);
	assign compare_value     = $signed(compare_value_q);
	assign mix_adjust        = mix_adjust_q;

	// Checks
	`MCI_ASSERT_SAME(a_live_cnt, clk, arst_n, 1'b1, st_q.lm_cnt == 3'($countones(st_q.lm_en)))
	`MCI_ASSERT_NEXT(a_load_shows, clk, arst_n, load_out, out_valid_q)
	`MCI_ASSERT_SAME(a_plain_res, clk, arst_n, out_valid_q && !is_command_q, !recognized_q && take_default_link_q)
	`MCI_ASSERT_SAME(a_stall_src, clk, arst_n, !in_ready, valid_s1 && out_valid_q && !out_ready)

endmodule
